@@ hdl/mexp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg - shared types and constants for modular exponentiation
// Sequencer states, operation codes, field widths and reducer handshake.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int BASE_W    = 63;               // base and exponent field width
	localparam int CFG_W     = 31;               // modulus register field width
	localparam int RES_W     = 31;               // result field width
	localparam int RED_W     = 64;               // reducer dividend width
	localparam int RED_DIGIT = 4;                // dividend bits consumed per cycle
	localparam int RED_STEPS = RED_W / RED_DIGIT;
	localparam int RED_CNT_W = $clog2(RED_STEPS);

	localparam logic [CFG_W-1:0] MOD_RESET = 31'd998244353;

	localparam logic CMD_POWER   = 1'b0;
	localparam logic CMD_INVERSE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED_START,
		S_WAIT,
		S_MUL,
		S_FINISH
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_BASE,
		OP_ACC,
		OP_SQ
	} seq_op_t;

	typedef struct packed {
		logic start;
	} red_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} red_sts_t;

endpackage

`default_nettype wire

@@ hdl/mexp_reduce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_reduce - iterative modular reducer
// Computes value mod modulus by restoring reduction, several bits a cycle.
// ----------------------------------------------------------------------------
module mexp_reduce #(
	parameter int MOD_BITS = 31
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mexp_pkg::red_req_t        req,
	input  wire logic [mexp_pkg::RED_W-1:0] value,
	input  wire logic [MOD_BITS-1:0]       mod_val,
	output      mexp_pkg::red_sts_t        sts,
	output      logic [MOD_BITS-1:0]       rem
);
	import mexp_pkg::*;

	logic [RED_W-1:0]     val_q;
	logic [MOD_BITS-1:0]  rem_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MOD_BITS-1:0]  rem_step;

	// Shift in one dividend bit per step; the partial remainder stays below
	// the modulus, so a single compare and subtract keeps it reduced.
	always_comb begin
		logic [MOD_BITS:0] t;
		rem_step = rem_q;
		for (int k = 0; k < RED_DIGIT; k++) begin
			t = {rem_step, val_q[RED_W-1-k]};
			if (t >= {1'b0, mod_val}) begin
				t = t - {1'b0, mod_val};
			end
			rem_step = t[MOD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= RED_CNT_W'(RED_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << RED_DIGIT;
			rem_q <= rem_step;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule

`default_nettype wire

@@ hdl/mexp_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_seq - square-and-multiply sequencer
// Holds accumulator, running square and exponent; drives multiplier/reducer.
// ----------------------------------------------------------------------------
module mexp_seq #(
	parameter int EXP_BITS = 63,
	parameter int MOD_BITS = 31
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        command,
	input  wire logic [mexp_pkg::BASE_W-1:0] base_value,
	input  wire logic [mexp_pkg::BASE_W-1:0] exponent,
	input  wire logic [MOD_BITS-1:0]         mod_val,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [mexp_pkg::RES_W-1:0]  result,
	output      mexp_pkg::red_req_t          red_req,
	output      logic [mexp_pkg::RED_W-1:0]  red_value,
	input  wire mexp_pkg::red_sts_t          red_sts,
	input  wire logic [MOD_BITS-1:0]         red_rem
);
	import mexp_pkg::*;

	seq_state_t state_q, state_d;
	seq_op_t    op_q, op_d;

	logic [BASE_W-1:0]     base_q;
	logic [EXP_BITS-1:0]   e_q;
	logic [EXP_BITS-1:0]   e_hi;
	logic [MOD_BITS-1:0]   acc_q;
	logic [MOD_BITS-1:0]   sq_q;
	logic [2*MOD_BITS-1:0] prod_q;
	logic [MOD_BITS-1:0]   mul_a;
	logic [RED_W-1:0]      inv_wide;
	logic [RES_W-1:0]      result_q;
	logic                  out_valid_q;
	logic                  mod_small;
	logic                  accept;
	logic                  finish_load;

	assign e_hi      = e_q >> 1;
	assign mod_small = (mod_val[MOD_BITS-1:1] == '0);
	assign inv_wide  = RED_W'(mod_val) - RED_W'(2);
	assign mul_a     = (op_q == OP_ACC) ? acc_q : sq_q;

	// next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = OP_BASE;
					state_d = mod_small ? S_FINISH : S_RED_START;
				end
			end
			S_RED_START: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (red_sts.done) begin
					unique case (op_q)
						OP_BASE: begin
							if (e_q == '0) begin
								state_d = S_FINISH;
							end else begin
								state_d = S_MUL;
								op_d    = e_q[0] ? OP_ACC : OP_SQ;
							end
						end
						OP_ACC: begin
							if (e_hi == '0) begin
								state_d = S_FINISH;
							end else begin
								state_d = S_MUL;
								op_d    = OP_SQ;
							end
						end
						OP_SQ: begin
							if (e_hi == '0) begin
								state_d = S_FINISH;
							end else begin
								state_d = S_MUL;
								op_d    = e_hi[0] ? OP_ACC : OP_SQ;
							end
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_MUL: begin
				state_d = S_RED_START;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		red_req.start = 1'b0;
		finish_load   = 1'b0;
		unique case (state_q)
			S_IDLE:      in_ready      = 1'b1;
			S_RED_START: red_req.start = 1'b1;
			S_FINISH:    finish_load   = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign red_value = (op_q == OP_BASE) ? RED_W'(base_q) : RED_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_BASE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (finish_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_value;
			e_q    <= (command == CMD_INVERSE) ? inv_wide[EXP_BITS-1:0]
			                                   : exponent[EXP_BITS-1:0];
			acc_q  <= mod_small ? '0 : MOD_BITS'(1);
		end
		if (state_q == S_WAIT && red_sts.done) begin
			unique case (op_q)
				OP_BASE: sq_q <= red_rem;
				OP_ACC:  acc_q <= red_rem;
				OP_SQ: begin
					sq_q <= red_rem;
					e_q  <= e_hi;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_a * sq_q;
		end
		if (finish_load) begin
			result_q <= RES_W'(acc_q);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation.sv @@
`default_nettype none
// A result needs one base reduction, one squaring per exponent bit below the highest set
// bit and one accumulate per set bit; a modulus below 2 skips all reductions and gives 0.
// Each modular multiply is a registered product reduced in the shared reducer,
// which retires 4 dividend bits a cycle; up to two run per exponent bit.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: arst_n clears the sequencer and output valid and loads modulus 998244353.
// ----------------------------------------------------------------------------
// modular_exponentiation - base ^ exponent mod modulus
// Right-to-left square-and-multiply on one shared multiplier and reducer.
// Command inverse uses modulus - 2 as the exponent (Fermat inverse).
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int EXP_BITS = 63,
	parameter int MOD_BITS = 31
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// modulus configuration channel
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [mexp_pkg::CFG_W-1:0]  modulus,
	// input item channel
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        command,
	input  wire logic [mexp_pkg::BASE_W-1:0] base_value,
	input  wire logic [mexp_pkg::BASE_W-1:0] exponent,
	// result channel
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [mexp_pkg::RES_W-1:0]  result
);
	import mexp_pkg::*;

	logic [MOD_BITS-1:0] modulus_q;
	red_req_t            red_req;
	red_sts_t            red_sts;
	logic [RED_W-1:0]    red_value;
	logic [MOD_BITS-1:0] red_rem;

	// Take modulus writes at any time; the host must write only while the block
	// is idle, which the block itself does not enforce. Only the low MOD_BITS bits are kept.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET[MOD_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= modulus[MOD_BITS-1:0];
		end
	end

	// Sequencer: reduce the base first, then walk the exponent from its low
	// end, multiplying the square into the accumulator on set bits and
	// squaring while higher set bits remain. Stop as soon as no set bit is
	// left, since the accumulator cannot change after that.
	mexp_seq #(
		.EXP_BITS (EXP_BITS),
		.MOD_BITS (MOD_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.base_value (base_value),
		.exponent   (exponent),
		.mod_val    (modulus_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result),
		.red_req    (red_req),
		.red_value  (red_value),
		.red_sts    (red_sts),
		.red_rem    (red_rem)
	);

	// Shared reducer: serves the base reduction and every product reduction.
	mexp_reduce #(
		.MOD_BITS (MOD_BITS)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (red_req),
		.value   (red_value),
		.mod_val (modulus_q),
		.sts     (red_sts),
		.rem     (red_rem)
	);

endmodule

`default_nettype wire
